### rtl/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg: constants shared by the combined LCG shuffle generator
// Moduli, multipliers, fold factors, table geometry and warm-up length.
// ----------------------------------------------------------------------------
package clsr_pkg;

  // Command codes
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_SEED = 1'b1;

  // Shuffle table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Seeding runs the first generator this many times before the first draw
  localparam int WARMUP      = TABLE_DEPTH + 8;
  localparam int CNT_W       = $clog2(WARMUP);

  // Generator word width
  localparam int GEN_W       = 31;
  localparam int PROD_W      = GEN_W + 16;

  // Both moduli sit just below 2^31: 2^31 mod m folds the high product bits
  localparam logic [31:0] MOD1  = 32'd2147483563;
  localparam logic [31:0] MOD2  = 32'd2147483399;
  localparam logic [31:0] FOLD1 = 32'h8000_0000 - MOD1;
  localparam logic [31:0] FOLD2 = 32'h8000_0000 - MOD2;
  localparam logic [15:0] MUL1  = 16'd40014;
  localparam logic [15:0] MUL2  = 16'd40692;

  // Output range and table bucket size
  localparam logic [31:0] OUT_MAX = MOD1 - 32'd1;
  localparam logic [31:0] BUCKET  = 32'd1 + OUT_MAX / TABLE_DEPTH;

  // Reset value of the second generator
  localparam logic [GEN_W-1:0] SECOND_RESET = 31'd123456789;

endpackage

### rtl/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng: combined LCG generator with a shuffle table
// Two congruential generators combined through a table of past values.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries command and seed_value.
//   command 0 draws the next number; command 1 loads seed_value (0 acts as
//   1), warms up the table and then draws. Every item gives exactly one
//   random_value in 1..2147483562 on the response channel (rsp_valid/
//   rsp_ready).
//   A draw runs these steps in order: table read at accept (registered
//   RAM read data), generator update with table write-back, then the
//   output subtract. The next draw needs the previous output to pick its
//   table entry, so a new item is taken only once the previous one has
//   left its last step.
//   A seed item adds 40 dependent generator steps, each through the
//   registered multiplier (SEED_MUL, then SEED_UPD), then the table
//   read of the entry picked by the freshly loaded output.
//   After reset the first generator is zero, so the first draw seeds with 1.
//   The table is not cleared; seeding always fills it before use.
//   A result waits in the output register while the receiver stalls; the
//   next item is still accepted and holds in its last step until the
//   register frees up.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       command,
  input  logic [clsr_pkg::GEN_W-1:0] seed_value,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [clsr_pkg::GEN_W-1:0] random_value
);

  typedef enum logic [2:0] {
    IDLE,
    SEED_MUL,
    SEED_UPD,
    DRAW_RD,
    DRAW_UPD,
    DRAW_OUT
  } state_t;

  state_t state;

  logic [clsr_pkg::GEN_W-1:0] first_gen;
  logic [clsr_pkg::GEN_W-1:0] second_gen;
  logic [clsr_pkg::GEN_W-1:0] last_output;
  logic [clsr_pkg::CNT_W-1:0] cnt;
  logic [clsr_pkg::IDX_W-1:0] idx_reg;

  logic [clsr_pkg::GEN_W-1:0] first_step;
  logic [clsr_pkg::GEN_W-1:0] second_step;
  logic [clsr_pkg::GEN_W-1:0] table_rdata;
  logic [clsr_pkg::IDX_W-1:0] table_raddr;
  logic [clsr_pkg::IDX_W-1:0] table_waddr;
  logic                       table_re;
  logic                       table_we;

  logic                       accept;
  logic                       need_seed;
  logic [clsr_pkg::GEN_W-1:0] seed_load;
  logic                       out_free;
  logic [31:0]                diff;
  logic [31:0]                draw_value;

  // Bucket of a previous output: number of bucket bounds at or below it
  function automatic logic [clsr_pkg::IDX_W-1:0] bucket_index(
    input logic [clsr_pkg::GEN_W-1:0] v
  );
    logic [clsr_pkg::IDX_W-1:0] idx;
    idx = '0;
    for (int k = 1; k < clsr_pkg::TABLE_DEPTH; k++) begin
      if ({1'b0, v} >= 32'(k) * clsr_pkg::BUCKET) begin
        idx = clsr_pkg::IDX_W'(k);
      end
    end
    return idx;
  endfunction

  // Generator step unit
  clsr_lcg u_lcg (
    .clk         (clk),
    .first_cur   (first_gen),
    .second_cur  (second_gen),
    .first_step  (first_step),
    .second_step (second_step)
  );

  // Shuffle table
  clsr_ram #(
    .WIDTH (clsr_pkg::GEN_W),
    .DEPTH (clsr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (table_waddr),
    .wdata (first_step),
    .re    (table_re),
    .raddr (table_raddr),
    .rdata (table_rdata)
  );

  // Handshake and seeding decision
  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign need_seed = (command == clsr_pkg::CMD_SEED) || (first_gen == '0);
  assign seed_load = (command == clsr_pkg::CMD_DRAW) ? clsr_pkg::GEN_W'(1) :
                     (seed_value == '0) ? clsr_pkg::GEN_W'(1) : seed_value;
  assign out_free  = !rsp_valid || rsp_ready;

  // Table access: read picks the entry of the previous output
  assign table_raddr = bucket_index(last_output);
  assign table_re    = (accept && !need_seed) || (state == DRAW_RD);
  assign table_we    = ((state == SEED_UPD) && (cnt < clsr_pkg::CNT_W'(clsr_pkg::TABLE_DEPTH)))
                       || (state == DRAW_UPD);
  assign table_waddr = (state == SEED_UPD) ? cnt[clsr_pkg::IDX_W-1:0] : idx_reg;

  // Output: table entry minus second generator, wrapped into range
  assign diff       = {1'b0, table_rdata} - {1'b0, second_gen};
  assign draw_value = (diff[31] || (diff == '0)) ? diff + clsr_pkg::OUT_MAX : diff;

  // Sequencer, generator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      rsp_valid   <= 1'b0;
      first_gen   <= '0;
      second_gen  <= clsr_pkg::SECOND_RESET;
      last_output <= '0;
    end else begin
      // Output register empties; a draw finishing now refills it below
      if (rsp_valid && rsp_ready && (state != DRAW_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            if (need_seed) begin
              first_gen  <= seed_load;
              second_gen <= seed_load;
              cnt        <= clsr_pkg::CNT_W'(clsr_pkg::WARMUP - 1);
              state      <= SEED_MUL;
            end else begin
              idx_reg <= table_raddr;
              state   <= DRAW_UPD;
            end
          end
        end
        SEED_MUL: begin
          state <= SEED_UPD;
        end
        SEED_UPD: begin
          // Warm-up step; the last steps fill the table top down
          first_gen <= first_step;
          if (cnt == '0) begin
            last_output <= first_step;
            state       <= DRAW_RD;
          end else begin
            cnt   <= cnt - clsr_pkg::CNT_W'(1);
            state <= SEED_MUL;
          end
        end
        DRAW_RD: begin
          idx_reg <= table_raddr;
          state   <= DRAW_UPD;
        end
        DRAW_UPD: begin
          // Advance both generators; the entry takes the new first value
          first_gen  <= first_step;
          second_gen <= second_step;
          state      <= DRAW_OUT;
        end
        DRAW_OUT: begin
          if (out_free) begin
            random_value <= draw_value[clsr_pkg::GEN_W-1:0];
            last_output  <= draw_value[clsr_pkg::GEN_W-1:0];
            rsp_valid    <= 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/clsr_ram.sv
// ----------------------------------------------------------------------------
// clsr_ram: simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clsr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/clsr_lcg.sv
// ----------------------------------------------------------------------------
// clsr_lcg: one step of both multiplicative congruential generators
// Products are registered; the next cycle folds the high bits back in
// (2^31 = fold mod m) and applies one conditional subtract.
// ----------------------------------------------------------------------------
module clsr_lcg (
  input  logic                       clk,
  input  logic [clsr_pkg::GEN_W-1:0] first_cur,
  input  logic [clsr_pkg::GEN_W-1:0] second_cur,
  output logic [clsr_pkg::GEN_W-1:0] first_step,
  output logic [clsr_pkg::GEN_W-1:0] second_step
);

  logic [clsr_pkg::PROD_W-1:0] prod1;
  logic [clsr_pkg::PROD_W-1:0] prod2;

  // z * a mod m for m = 2^31 - fold; the folded sum stays below 2m
  function automatic logic [clsr_pkg::GEN_W-1:0] fold_mod(
    input logic [clsr_pkg::PROD_W-1:0] p,
    input logic [31:0]                 fold,
    input logic [31:0]                 modulus
  );
    logic [31:0] hi_part;
    logic [31:0] sum;
    hi_part = 32'(p[clsr_pkg::PROD_W-1:clsr_pkg::GEN_W]) * fold;
    sum     = hi_part + {1'b0, p[clsr_pkg::GEN_W-1:0]};
    if (sum >= modulus) begin
      sum = sum - modulus;
    end
    return sum[clsr_pkg::GEN_W-1:0];
  endfunction

  // Multiply stage
  always_ff @(posedge clk) begin
    prod1 <= clsr_pkg::PROD_W'(first_cur) * clsr_pkg::PROD_W'(clsr_pkg::MUL1);
    prod2 <= clsr_pkg::PROD_W'(second_cur) * clsr_pkg::PROD_W'(clsr_pkg::MUL2);
  end

  // Reduction stage
  assign first_step  = fold_mod(prod1, clsr_pkg::FOLD1, clsr_pkg::MOD1);
  assign second_step = fold_mod(prod2, clsr_pkg::FOLD2, clsr_pkg::MOD2);

endmodule

### bench/clsr_checker.sv
// ----------------------------------------------------------------------------
// clsr_checker: result predictor and scoreboard for combined_lcg_shuffle_rng
// Watches both channels, runs its own copy of the two congruential generators
// and the shuffle table for each accepted item, and compares each result
// with the oldest expected value. Mismatches and leftovers go to the top.
// ----------------------------------------------------------------------------
module clsr_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  logic                       command,
  input  logic [clsr_pkg::GEN_W-1:0] seed_value,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  logic [clsr_pkg::GEN_W-1:0] random_value,
  output int                         mismatches,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import clsr_pkg::*;

  // Generator constants (Schrage split of each modulus)
  localparam longint MOD_ONE  = longint'(MOD1);
  localparam longint MOD_TWO  = longint'(MOD2);
  localparam longint MULT_ONE = longint'(MUL1);
  localparam longint MULT_TWO = longint'(MUL2);
  localparam longint QUOT_ONE = 53668;
  localparam longint QUOT_TWO = 52774;
  localparam longint REM_ONE  = 12211;
  localparam longint REM_TWO  = 3791;
  localparam longint TOP_OUT  = longint'(OUT_MAX);
  localparam longint SLOT_DIV = longint'(BUCKET);

  // Predicted generator state
  longint gen_one;
  longint gen_two;
  longint prev_draw;
  longint shuffle_slots [TABLE_DEPTH];

  logic [GEN_W-1:0] expected_values [$];
  logic [GEN_W-1:0] want;

  // One multiplicative congruential step without overflow
  function automatic longint congruential_next(longint z, longint mul, longint q,
                                               longint r, longint m);
    longint hi;
    longint v;
    hi = z / q;
    v  = mul * (z - hi * q) - hi * r;
    if (v < 0) v += m;
    return v;
  endfunction

  // Seed both generators and refill the table from the top entry down
  function automatic void load_seed(longint s);
    if (s < 1) s = 1;
    gen_one = s;
    gen_two = s;
    for (int n = WARMUP - 1; n >= 0; n--) begin
      gen_one = congruential_next(gen_one, MULT_ONE, QUOT_ONE, REM_ONE, MOD_ONE);
      if (n < TABLE_DEPTH) shuffle_slots[n] = gen_one;
    end
    prev_draw = shuffle_slots[0];
  endfunction

  // Next shuffled output for one item
  function automatic logic [GEN_W-1:0] next_random(logic cmd, logic [GEN_W-1:0] seed);
    longint slot;
    longint y;
    if (cmd == CMD_SEED) load_seed(longint'(seed));
    else if (gen_one == 0) load_seed(1);
    gen_one = congruential_next(gen_one, MULT_ONE, QUOT_ONE, REM_ONE, MOD_ONE);
    gen_two = congruential_next(gen_two, MULT_TWO, QUOT_TWO, REM_TWO, MOD_TWO);
    slot = prev_draw / SLOT_DIV;
    if (slot < 0) slot = 0;
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    y = shuffle_slots[slot] - gen_two;
    shuffle_slots[slot] = gen_one;
    if (y < 1) y += TOP_OUT;
    prev_draw = y;
    return y[GEN_W-1:0];
  endfunction

  // Scoreboard: check results first, then queue the prediction for a new item
  always @(posedge clk) begin
    if (rst) begin
      gen_one   = 0;
      gen_two   = longint'(SECOND_RESET);
      prev_draw = 0;
      foreach (shuffle_slots[i]) shuffle_slots[i] = 0;
      expected_values.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_values.size() == 0) begin
          $error("random_value: no item expected, actual %0d", random_value);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) begin
            $error("random_value: expected %0d, actual %0d", want, random_value);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready)
        expected_values.push_back(next_random(command, seed_value));
      outstanding = expected_values.size();
    end
  end

endmodule

### bench/tb_combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// tb_combined_lcg_shuffle_rng: regression for the combined LCG shuffle block
// Directed seeds and draws (reset draw, zero seed, seeds at and above the
// moduli), then random draw runs with occasional reseeds, with random idle
// bursts on both channels except in the final quiet phases. Checking lives in clsr_checker.
// ----------------------------------------------------------------------------
module tb_combined_lcg_shuffle_rng;
  timeunit 1ns;
  timeprecision 1ps;

  import clsr_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int QUIET_FROM  = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN       = 12;

  localparam logic [GEN_W-1:0] SEED_MAX = {GEN_W{1'b1}};

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             req_valid  = 1'b0;
  logic             req_ready;
  logic             command    = CMD_DRAW;
  logic [GEN_W-1:0] seed_value = '0;
  logic             rsp_valid;
  logic             rsp_ready  = 1'b0;
  logic [GEN_W-1:0] random_value;

  int mismatches;
  int outstanding;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int seed_pct   = 0;
  int stall_left = 0;
  int cycles     = 0;

  combined_lcg_shuffle_rng dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .command      (command),
    .seed_value   (seed_value),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .random_value (random_value)
  );

  clsr_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .command      (command),
    .seed_value   (seed_value),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .random_value (random_value),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("combined_lcg_shuffle_rng regression: fail");
      $finish;
    end
  end

  // Receiver stalls in bursts whose remaining length stall_left counts down
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      rsp_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Present one item at a falling edge, hold it until taken, maybe idle after
  task automatic send_item(input logic cmd, input logic [GEN_W-1:0] seed);
    req_valid  <= 1'b1;
    command    <= cmd;
    seed_value <= seed;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // Mostly full-range seeds, sometimes zero, one, the largest or a modulus edge
  function automatic logic [GEN_W-1:0] pick_seed();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 9) != 0) return raw[GEN_W-1:0];
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return GEN_W'(1);
      2:       return MOD1[GEN_W-1:0];
      3:       return MOD2[GEN_W-1:0];
      4:       return OUT_MAX[GEN_W-1:0];
      5:       return MOD2[GEN_W-1:0] + GEN_W'(1);
      default: return SEED_MAX;
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    logic [31:0] noise;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: draws straight after reset seed the first generator with 1
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, SEED_MAX);
    // Zero seed acts as 1
    send_item(CMD_SEED, '0);
    send_item(CMD_DRAW, '0);
    send_item(CMD_SEED, GEN_W'(1));
    // Largest seed, above both moduli
    send_item(CMD_SEED, SEED_MAX);
    send_item(CMD_DRAW, '0);
    // Seed equal to the first modulus zeroes the first generator: next draw reseeds
    send_item(CMD_SEED, MOD1[GEN_W-1:0]);
    send_item(CMD_DRAW, '0);
    send_item(CMD_DRAW, '0);
    // Seed equal to the second modulus sticks the second generator at zero
    send_item(CMD_SEED, MOD2[GEN_W-1:0]);
    repeat (3) send_item(CMD_DRAW, SEED_MAX);
    send_item(CMD_SEED, OUT_MAX[GEN_W-1:0]);
    send_item(CMD_SEED, MOD2[GEN_W-1:0] - GEN_W'(1));
    send_item(CMD_SEED, MOD2[GEN_W-1:0] + GEN_W'(1));
    send_item(CMD_SEED, GEN_W'(31'h2AAA_AAAA));
    send_item(CMD_DRAW, GEN_W'(31'h5555_5555));
    send_item(CMD_SEED, GEN_W'(31'h5555_5555));
    send_item(CMD_SEED, GEN_W'(12345));
    repeat (4) send_item(CMD_DRAW, '0);

    // Random: long draw runs with occasional reseeds, idling varies per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase >= QUIET_FROM) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      seed_pct = $urandom_range(2, 15);
      repeat (PHASE_ITEMS) begin
        noise = $urandom;
        if ($urandom_range(0, 99) < seed_pct) send_item(CMD_SEED, pick_seed());
        else send_item(CMD_DRAW, noise[GEN_W-1:0]);
      end
    end
    req_valid <= 1'b0;

    // Drain, then a few more cycles for stray results
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("combined_lcg_shuffle_rng regression: pass");
    else
      $display("combined_lcg_shuffle_rng regression: fail");
    $finish;
  end

endmodule

### sim.f
rtl/clsr_pkg.sv
rtl/clsr_ram.sv
rtl/clsr_lcg.sv
rtl/combined_lcg_shuffle_rng.sv
bench/clsr_checker.sv
bench/tb_combined_lcg_shuffle_rng.sv
